// File: rtl/core/aabb_cg_pkg.sv
// ----------------------------------------------------------------------------
// aabb_cg_pkg
// Shared types for the AABB contact generator: box pair and contact record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aabb_cg_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned WideW  = 17;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [WideW-1:0]  wide_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
  } box_t;

  typedef struct packed {
    box_t a;
    box_t b;
  } box_pair_t;

  typedef struct packed {
    logic   overlapping;
    logic   normal_on_y;
    logic   normal_negative;
    wide_t  depth;
    wide_t  contact_x_doubled;
    wide_t  contact_y_doubled;
    coord_t overlap_min_x;
    coord_t overlap_min_y;
    wide_t  overlap_width;
    wide_t  overlap_height;
  } contact_t;

endpackage

`default_nettype wire

// File: rtl/core/aabb_contact_generator_unit.sv
// ----------------------------------------------------------------------------
// aabb_contact_generator_unit
// Contact generator for pairs of 2D axis-aligned boxes, one pair per cycle when not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one box pair per request (A then B corners, Q11.4).
//   m_axis returns exactly one contact record per request, in order;
//   m_axis_tuser is the overlap flag, m_axis_tdata the contact fields.
//   The accept edge loads the input register; the result register then
//   loads through the contact math once the output can advance.
//   Throughput is one pair per cycle while the receiver keeps up; the
//   combinational contact math between the two registers sets that figure.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more request; s_axis_tready drops only when
//   both registers are full and m_axis_tready is low.
//   Reset (rst, synchronous) empties both registers; no other state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabb_contact_generator_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // a_min_x, a_min_y, a_max_x, a_max_y, b_min_x, b_min_y, b_max_x, b_max_y
  input  wire logic [127:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // normal_on_y, normal_negative, depth, contact_x_doubled,
  // contact_y_doubled, overlap_min_x, overlap_min_y, overlap_width,
  // overlap_height, one zero pad bit
  output logic [119:0]      m_axis_tdata,
  // overlapping
  output logic              m_axis_tuser
);

  aabb_cg_pkg::box_pair_t pair;
  logic                   pair_valid;
  aabb_cg_pkg::contact_t  contact_next;
  aabb_cg_pkg::contact_t  contact;
  logic                   advance;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !pair_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) pair_valid <= s_axis_tvalid;
      if (advance) m_axis_tvalid <= pair_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      pair.a.min_x <= s_axis_tdata[15:0];
      pair.a.min_y <= s_axis_tdata[31:16];
      pair.a.max_x <= s_axis_tdata[47:32];
      pair.a.max_y <= s_axis_tdata[63:48];
      pair.b.min_x <= s_axis_tdata[79:64];
      pair.b.min_y <= s_axis_tdata[95:80];
      pair.b.max_x <= s_axis_tdata[111:96];
      pair.b.max_y <= s_axis_tdata[127:112];
    end
    if (advance && pair_valid) contact <= contact_next;
  end

  aabb_cg_calc u_calc (
    .pair    (pair),
    .contact (contact_next)
  );

  assign m_axis_tuser = contact.overlapping;
  assign m_axis_tdata = {1'b0,
                         contact.overlap_height,
                         contact.overlap_width,
                         contact.overlap_min_y,
                         contact.overlap_min_x,
                         contact.contact_y_doubled,
                         contact.contact_x_doubled,
                         contact.depth,
                         contact.normal_negative,
                         contact.normal_on_y};

  // an accepted request always lands in the input register
  a_accept_lands : assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> pair_valid)
    else $error("accepted request lost before input register");

  // a full input register behind a stalled result must block the input
  a_no_overrun : assert property (@(posedge clk) disable iff (rst)
    (pair_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while both registers full and stalled");

  // chosen axis carries the smaller penetration, y on a tie
  a_axis_choice : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (contact.normal_on_y ?
         (contact.overlap_height <= contact.overlap_width &&
          contact.depth == contact.overlap_height) :
         (contact.overlap_width < contact.overlap_height &&
          contact.depth == contact.overlap_width)))
    else $error("normal axis does not match smaller penetration");

endmodule

`default_nettype wire

// File: rtl/core/aabb_cg_calc.sv
// ----------------------------------------------------------------------------
// aabb_cg_calc
// Combinational contact math for one box pair: overlap test, overlap box,
// penetrations, normal axis and sign, doubled contact point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabb_cg_calc (
  input  wire aabb_cg_pkg::box_pair_t pair,
  output aabb_cg_pkg::contact_t       contact
);

  aabb_cg_pkg::coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  aabb_cg_pkg::coord_t cx0, cy0, cx1, cy1;
  aabb_cg_pkg::wide_t  px, py;
  // edge gaps used by the sign flip rules
  aabb_cg_pkg::wide_t  gap_by0_ay0, gap_ay1_by1, gap_bx0_ax0, gap_ax1_bx1;
  aabb_cg_pkg::wide_t  gap_ax0_bx0, gap_bx1_ax1, gap_ay0_by0, gap_by1_ay1;
  logic                hit, on_y, nx_neg, ny_neg;

  assign ax0 = pair.a.min_x;
  assign ay0 = pair.a.min_y;
  assign ax1 = pair.a.max_x;
  assign ay1 = pair.a.max_y;
  assign bx0 = pair.b.min_x;
  assign by0 = pair.b.min_y;
  assign bx1 = pair.b.max_x;
  assign by1 = pair.b.max_y;

  assign hit = !((ax0 > bx1) || (bx0 > ax1) || (ay0 > by1) || (by0 > ay1));

  assign cx0 = (ax0 > bx0) ? ax0 : bx0;
  assign cy0 = (ay0 > by0) ? ay0 : by0;
  assign cx1 = (ax1 < bx1) ? ax1 : bx1;
  assign cy1 = (ay1 < by1) ? ay1 : by1;

  assign px = 17'(cx1) - 17'(cx0);
  assign py = 17'(cy1) - 17'(cy0);

  assign gap_by0_ay0 = 17'(by0) - 17'(ay0);
  assign gap_ay1_by1 = 17'(ay1) - 17'(by1);
  assign gap_bx0_ax0 = 17'(bx0) - 17'(ax0);
  assign gap_ax1_bx1 = 17'(ax1) - 17'(bx1);
  assign gap_ax0_bx0 = 17'(ax0) - 17'(bx0);
  assign gap_bx1_ax1 = 17'(bx1) - 17'(ax1);
  assign gap_ay0_by0 = 17'(ay0) - 17'(by0);
  assign gap_by1_ay1 = 17'(by1) - 17'(ay1);

  always_comb begin
    nx_neg = !(ax0 <= bx0);
    ny_neg = !(ay0 <= by0);
    if (ax0 <= bx0) begin
      if (ay0 <= by0) begin
        if (!(ax1 > bx1) && (ay1 > by1) && (gap_by0_ay0 < gap_ay1_by1)) begin
          ny_neg = 1'b1;
        end
      end else begin
        if ((ay1 < by1) && !(ax1 < bx1) && (gap_bx0_ax0 < gap_ax1_bx1)) begin
          nx_neg = 1'b1;
        end
      end
    end else begin
      if (ay0 <= by0) begin
        if (ax1 < bx1) begin
          if (ay1 < by1) begin
            if (gap_ax0_bx0 < gap_bx1_ax1) nx_neg = 1'b0;
          end else begin
            if (gap_by0_ay0 < gap_ay1_by1) ny_neg = 1'b1;
          end
        end else if (ay1 > by1) begin
          if (gap_by0_ay0 < gap_ay1_by1) ny_neg = 1'b1;
        end
      end else begin
        if (ax1 < bx1) begin
          if (gap_ax0_bx0 < gap_bx1_ax1) nx_neg = 1'b0;
        end else if (ay1 < by1) begin
          if (gap_ay0_by0 < gap_by1_ay1) ny_neg = 1'b0;
        end
      end
    end
  end

  // y axis wins a tie
  assign on_y = !(px < py);

  always_comb begin
    contact.overlapping       = hit;
    contact.normal_on_y       = on_y;
    contact.normal_negative   = on_y ? ny_neg : nx_neg;
    contact.depth             = on_y ? py : px;
    contact.contact_x_doubled = 17'(cx0) + 17'(cx1);
    contact.contact_y_doubled = 17'(cy0) + 17'(cy1);
    contact.overlap_min_x     = cx0;
    contact.overlap_min_y     = cy0;
    contact.overlap_width     = px;
    contact.overlap_height    = py;
  end

endmodule

`default_nettype wire

// File: sim/tb_aabb_contact_generator_unit.sv
// ----------------------------------------------------------------------------
// tb_aabb_contact_generator_unit
// Streams box pairs through the contact generator and checks each contact
// record against a local model of the overlap, normal and centroid rules.
// A directed table covers the extremes and every normal flip case, then
// random pairs (mostly near or overlapping boxes) run under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_aabb_contact_generator_unit;

  localparam int RandPairs      = 850;
  localparam int QuietTail      = 100;
  localparam int SinkHoldAt     = 150;
  localparam int SinkHoldCycles = 80;
  localparam int DrainAt        = 400;
  localparam int DirRows        = 20;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;
  logic         m_axis_tuser;

  aabb_cg_pkg::contact_t contact_q[$];
  aabb_cg_pkg::contact_t got_rec;
  aabb_cg_pkg::contact_t head_rec;
  int       err_count = 0;
  bit       quiet     = 1'b0;
  bit       hold_req  = 1'b0;
  bit       hold_done = 1'b0;

  // columns: a_min_x a_min_y a_max_x a_max_y b_min_x b_min_y b_max_x b_max_y,
  // typed flag, then overlapping normal_on_y normal_negative depth cx2 cy2
  // overlap_min_x overlap_min_y overlap_width overlap_height
  int dir_rows [DirRows][19] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0,  1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767,
      1, 0, 1, 0, -65535, -1, -1, 32767, 32767, -65535, -65535},
    '{32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768,
      1, 0, 1, 1, -65535, -1, -1, 32767, 32767, -65535, -65535},
    '{-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767,
      1, 1, 1, 0, 65535, -1, -1, -32768, -32768, 65535, 65535},
    // left-bottom entry, taller A: y flips negative
    '{0, 0, 10, 100, 0, 10, 10, 20,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // left-top entry, A shorter and not thinner: x flips negative
    '{0, 10, 100, 20, 10, 0, 15, 100,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // right-bottom entry, A thinner and shorter: x flips positive
    '{10, 0, 15, 50, 0, 10, 100, 100,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // right-bottom entry, A thinner, not shorter: y flips negative
    '{10, 0, 20, 100, 0, 10, 100, 20,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // right-bottom entry, A not thinner and taller: y flips negative
    '{10, 0, 100, 100, 0, 10, 20, 20,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // right-top entry, A thinner: x flips positive
    '{10, 10, 15, 20, 0, 0, 100, 100,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // right-top entry, A not thinner and shorter: y flips positive
    '{10, 10, 100, 15, 0, 0, 20, 100,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // left-bottom taller A, opposite side not deeper: no flip
    '{0, 0, 10, 30, 0, 20, 10, 25,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 10, 10, 10, 0, 20, 10,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 10, 10, 11, 0, 20, 10,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 10, 10, 0, -20, 10, -1,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{10, 10, 0, 0, 0, 0, 10, 10,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{5, -5, -5, 5, -3, 3, 3, -3,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{-16, -16, 16, 16, -32768, 0, 32767, 32767,
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{5, 5, 20, 20, 0, 0, 10, 10,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{-32768, 32767, 32767, -32768, 0, 0, 0, 0,
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
  };

  aabb_contact_generator_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic aabb_cg_pkg::box_pair_t to_pair(input int c[8]);
    aabb_cg_pkg::box_pair_t p;
    p.a.min_x = aabb_cg_pkg::coord_t'(c[0]);
    p.a.min_y = aabb_cg_pkg::coord_t'(c[1]);
    p.a.max_x = aabb_cg_pkg::coord_t'(c[2]);
    p.a.max_y = aabb_cg_pkg::coord_t'(c[3]);
    p.b.min_x = aabb_cg_pkg::coord_t'(c[4]);
    p.b.min_y = aabb_cg_pkg::coord_t'(c[5]);
    p.b.max_x = aabb_cg_pkg::coord_t'(c[6]);
    p.b.max_y = aabb_cg_pkg::coord_t'(c[7]);
    return p;
  endfunction

  function automatic aabb_cg_pkg::contact_t predict_contact(
    input aabb_cg_pkg::box_pair_t p);
    int       ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    int       cx0, cy0, cx1, cy1, px, py;
    bit       nx_neg, ny_neg, on_y;
    aabb_cg_pkg::contact_t r;
    ax0 = p.a.min_x;
    ay0 = p.a.min_y;
    ax1 = p.a.max_x;
    ay1 = p.a.max_y;
    bx0 = p.b.min_x;
    by0 = p.b.min_y;
    bx1 = p.b.max_x;
    by1 = p.b.max_y;
    cx0 = (ax0 > bx0) ? ax0 : bx0;
    cy0 = (ay0 > by0) ? ay0 : by0;
    cx1 = (ax1 < bx1) ? ax1 : bx1;
    cy1 = (ay1 < by1) ? ay1 : by1;
    nx_neg = ax0 > bx0;
    ny_neg = ay0 > by0;
    // sign flips only when the opposite side's overlap is strictly deeper
    if (ax0 <= bx0) begin
      if (ay0 <= by0) begin
        if (ax1 <= bx1 && ay1 > by1 && (by0 - ay0) < (ay1 - by1)) ny_neg = 1'b1;
      end else begin
        if (ay1 < by1 && ax1 >= bx1 && (bx0 - ax0) < (ax1 - bx1)) nx_neg = 1'b1;
      end
    end else if (ay0 <= by0) begin
      if (ax1 < bx1) begin
        if (ay1 < by1) begin
          if ((ax0 - bx0) < (bx1 - ax1)) nx_neg = 1'b0;
        end else if ((by0 - ay0) < (ay1 - by1)) begin
          ny_neg = 1'b1;
        end
      end else if (ay1 > by1 && (by0 - ay0) < (ay1 - by1)) begin
        ny_neg = 1'b1;
      end
    end else begin
      if (ax1 < bx1) begin
        if ((ax0 - bx0) < (bx1 - ax1)) nx_neg = 1'b0;
      end else if (ay1 < by1 && (ay0 - by0) < (by1 - ay1)) begin
        ny_neg = 1'b0;
      end
    end
    px = cx1 - cx0;
    py = cy1 - cy0;
    on_y = !(px < py);
    r.overlapping       = !(ax0 > bx1 || bx0 > ax1 || ay0 > by1 || by0 > ay1);
    r.normal_on_y       = on_y;
    r.normal_negative   = on_y ? ny_neg : nx_neg;
    r.depth             = aabb_cg_pkg::wide_t'(on_y ? py : px);
    r.contact_x_doubled = aabb_cg_pkg::wide_t'(cx0 + cx1);
    r.contact_y_doubled = aabb_cg_pkg::wide_t'(cy0 + cy1);
    r.overlap_min_x     = aabb_cg_pkg::coord_t'(cx0);
    r.overlap_min_y     = aabb_cg_pkg::coord_t'(cy0);
    r.overlap_width     = aabb_cg_pkg::wide_t'(px);
    r.overlap_height    = aabb_cg_pkg::wide_t'(py);
    return r;
  endfunction

  // mostly near or overlapping boxes; the rest full-range noise and corners
  function automatic aabb_cg_pkg::box_pair_t random_pair();
    int c[8];
    int span, mode, a_lo, b_lo;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      for (int j = 0; j < 8; j++) c[j] = int'(aabb_cg_pkg::coord_t'($urandom));
    end else if (mode == 2) begin
      for (int j = 0; j < 8; j++) begin
        case ($urandom_range(0, 4))
          0: c[j] = -32768;
          1: c[j] = -1;
          2: c[j] = 0;
          3: c[j] = 32767;
          default: c[j] = int'(aabb_cg_pkg::coord_t'($urandom));
        endcase
      end
    end else begin
      span = $urandom_range(0, 1) ? 16 : 2000;
      for (int k = 0; k < 2; k++) begin
        a_lo = int'($urandom_range(0, 58000)) - 30000;
        b_lo = a_lo + int'($urandom_range(0, 2 * span + 8)) - span - 4;
        c[k]     = a_lo;
        c[k + 2] = a_lo + int'($urandom_range(0, span));
        c[k + 4] = b_lo;
        c[k + 6] = b_lo + int'($urandom_range(0, span));
      end
    end
    return to_pair(c);
  endfunction

  task automatic sender_gap();
    if (!quiet && !(hold_req && !hold_done) && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send_pair(input aabb_cg_pkg::box_pair_t p, input bit typed,
                           input aabb_cg_pkg::contact_t typed_rec);
    s_axis_tdata  <= {p.b.max_y, p.b.max_x, p.b.min_y, p.b.min_x,
                      p.a.max_y, p.a.max_x, p.a.min_y, p.a.min_x};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    contact_q.push_back(typed ? typed_rec : predict_contact(p));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (contact_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input aabb_cg_pkg::wide_t want,
                             input aabb_cg_pkg::wide_t got);
    if (got !== want) begin
      err_count++;
      if (err_count <= 10)
        $display("contact mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // request driver
  initial begin
    int                     c[8];
    aabb_cg_pkg::contact_t  typed_rec;
    aabb_cg_pkg::box_pair_t p;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DirRows; i++) begin
      for (int j = 0; j < 8; j++) c[j] = dir_rows[i][j];
      typed_rec.overlapping       = dir_rows[i][9][0];
      typed_rec.normal_on_y       = dir_rows[i][10][0];
      typed_rec.normal_negative   = dir_rows[i][11][0];
      typed_rec.depth             = aabb_cg_pkg::wide_t'(dir_rows[i][12]);
      typed_rec.contact_x_doubled = aabb_cg_pkg::wide_t'(dir_rows[i][13]);
      typed_rec.contact_y_doubled = aabb_cg_pkg::wide_t'(dir_rows[i][14]);
      typed_rec.overlap_min_x     = aabb_cg_pkg::coord_t'(dir_rows[i][15]);
      typed_rec.overlap_min_y     = aabb_cg_pkg::coord_t'(dir_rows[i][16]);
      typed_rec.overlap_width     = aabb_cg_pkg::wide_t'(dir_rows[i][17]);
      typed_rec.overlap_height    = aabb_cg_pkg::wide_t'(dir_rows[i][18]);
      sender_gap();
      send_pair(to_pair(c), dir_rows[i][8] != 0, typed_rec);
    end
    for (int n = 0; n < RandPairs; n++) begin
      if (n == SinkHoldAt) hold_req = 1'b1;
      if (n == DrainAt) wait_drained();
      if (n == RandPairs - QuietTail) quiet = 1'b1;
      p = random_pair();
      sender_gap();
      send_pair(p, 1'b0, typed_rec);
    end
    wait_drained();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_aabb_contact_generator_unit passed");
    end else begin
      $display("tb_aabb_contact_generator_unit failed");
    end
    $finish;
  end

  // result sink with random back-pressure and one long hold-off
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (SinkHoldCycles) @(posedge clk);
        hold_done = 1'b1;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_rec.overlapping       = m_axis_tuser;
      got_rec.normal_on_y       = m_axis_tdata[0];
      got_rec.normal_negative   = m_axis_tdata[1];
      got_rec.depth             = m_axis_tdata[18:2];
      got_rec.contact_x_doubled = m_axis_tdata[35:19];
      got_rec.contact_y_doubled = m_axis_tdata[52:36];
      got_rec.overlap_min_x     = m_axis_tdata[68:53];
      got_rec.overlap_min_y     = m_axis_tdata[84:69];
      got_rec.overlap_width     = m_axis_tdata[101:85];
      got_rec.overlap_height    = m_axis_tdata[118:102];
      if (contact_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("contact record with no request pending");
      end else begin
        head_rec = contact_q.pop_front();
        check_field("overlapping", head_rec.overlapping, got_rec.overlapping);
        check_field("normal_on_y", head_rec.normal_on_y, got_rec.normal_on_y);
        check_field("normal_negative", head_rec.normal_negative, got_rec.normal_negative);
        check_field("depth", head_rec.depth, got_rec.depth);
        check_field("contact_x_doubled", head_rec.contact_x_doubled,
                    got_rec.contact_x_doubled);
        check_field("contact_y_doubled", head_rec.contact_y_doubled,
                    got_rec.contact_y_doubled);
        check_field("overlap_min_x", head_rec.overlap_min_x, got_rec.overlap_min_x);
        check_field("overlap_min_y", head_rec.overlap_min_y, got_rec.overlap_min_y);
        check_field("overlap_width", head_rec.overlap_width, got_rec.overlap_width);
        check_field("overlap_height", head_rec.overlap_height, got_rec.overlap_height);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_aabb_contact_generator_unit failed");
    $finish;
  end

endmodule

// File: aabb_contact_generator_unit.f
rtl/core/aabb_cg_pkg.sv
rtl/core/aabb_cg_calc.sv
rtl/core/aabb_contact_generator_unit.sv
sim/tb_aabb_contact_generator_unit.sv
